// File: rtl/dvb_text_to_utf8_decoder_macros.svh
// Assertion macros used by the DVB text decoder RTL.
`ifndef DVB_TEXT_TO_UTF8_DECODER_MACROS_SVH
`define DVB_TEXT_TO_UTF8_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge out of reset.
`define DVBU_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Check that a consequent follows an antecedent in the same cycle.
`define DVBU_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`else

`define DVBU_ASSERT_ALWAYS(label, clk, rstn, expr, msg)
`define DVBU_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)

`endif

`endif

// File: rtl/dvbu_pkg.sv
// Types, table codes and character ROMs of the DVB text decoder.
`default_nettype none

package dvbu_pkg;

    // Character table codes
    localparam logic [1:0] MODE_PASS   = 2'd0;
    localparam logic [1:0] MODE_8859_5 = 2'd1;
    localparam logic [1:0] MODE_8859_9 = 2'd2;
    localparam logic [1:0] MODE_6937   = 2'd3;

    typedef logic [15:0] cp_t;

    // Code point handed from the front to the queue
    typedef struct packed {
        logic valid;
        cp_t  cp;
    } cp_push_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

    // Serializer status
    typedef struct packed {
        logic busy;
    } back_stat_t;

    // ISO 6937 range 0xA8-0xBA
    function automatic cp_t rom_a8(input logic [4:0] idx);
        cp_t r;
        case (idx)
            5'd0:    r = 16'h00A4;
            5'd1:    r = 16'h2018;
            5'd2:    r = 16'h201C;
            5'd3:    r = 16'h00AB;
            5'd4:    r = 16'h2190;
            5'd5:    r = 16'h2191;
            5'd6:    r = 16'h2192;
            5'd7:    r = 16'h2193;
            5'd8:    r = 16'h00B0;
            5'd9:    r = 16'h00B1;
            5'd10:   r = 16'h00B2;
            5'd11:   r = 16'h00B3;
            5'd12:   r = 16'h00D7;
            5'd13:   r = 16'h00B5;
            5'd14:   r = 16'h00B6;
            5'd15:   r = 16'h00B7;
            5'd16:   r = 16'h00F7;
            5'd17:   r = 16'h2019;
            5'd18:   r = 16'h201D;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

    // ISO 6937 range 0xD0-0xD7
    function automatic cp_t rom_d0(input logic [2:0] idx);
        cp_t r;
        case (idx)
            3'd0:    r = 16'h2014;
            3'd1:    r = 16'h00B9;
            3'd2:    r = 16'h00AE;
            3'd3:    r = 16'h00A9;
            3'd4:    r = 16'h2122;
            3'd5:    r = 16'h266A;
            3'd6:    r = 16'h00AC;
            3'd7:    r = 16'h00A6;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

    // ISO 6937 range 0xDC-0xFF
    function automatic cp_t rom_dc(input logic [5:0] idx);
        cp_t r;
        case (idx)
            6'd0:    r = 16'h215B;
            6'd1:    r = 16'h215C;
            6'd2:    r = 16'h215D;
            6'd3:    r = 16'h215E;
            6'd4:    r = 16'h2126;
            6'd5:    r = 16'h00C6;
            6'd6:    r = 16'h00D0;
            6'd7:    r = 16'h00AA;
            6'd8:    r = 16'h0126;
            6'd9:    r = 16'h00E5;
            6'd10:   r = 16'h0132;
            6'd11:   r = 16'h013F;
            6'd12:   r = 16'h0141;
            6'd13:   r = 16'h00D8;
            6'd14:   r = 16'h0152;
            6'd15:   r = 16'h00BA;
            6'd16:   r = 16'h00DE;
            6'd17:   r = 16'h0166;
            6'd18:   r = 16'h014A;
            6'd19:   r = 16'h0149;
            6'd20:   r = 16'h0138;
            6'd21:   r = 16'h00E6;
            6'd22:   r = 16'h0111;
            6'd23:   r = 16'h00F0;
            6'd24:   r = 16'h0127;
            6'd25:   r = 16'h0131;
            6'd26:   r = 16'h0133;
            6'd27:   r = 16'h0140;
            6'd28:   r = 16'h0142;
            6'd29:   r = 16'h00F8;
            6'd30:   r = 16'h0153;
            6'd31:   r = 16'h00DF;
            6'd32:   r = 16'h00FE;
            6'd33:   r = 16'h0167;
            6'd34:   r = 16'h014B;
            6'd35:   r = 16'h00AD;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

    // Translate one byte through the selected table
    function automatic cp_t map_byte(input logic [1:0] mode, input logic [7:0] b);
        cp_t r;
        logic [7:0] off;
        r   = {8'h00, b};
        off = 8'h00;
        case (mode)
            MODE_8859_5: begin
                if (b >= 8'hA1 && b != 8'hAD) begin
                    if (b == 8'hF0) begin
                        r = 16'h2116;
                    end else if (b == 8'hFD) begin
                        r = 16'h00A7;
                    end else begin
                        r = {8'h00, b} + 16'h0360;
                    end
                end
            end
            MODE_8859_9: begin
                case (b)
                    8'hD0:   r = 16'h011E;
                    8'hDD:   r = 16'h0130;
                    8'hDE:   r = 16'h015E;
                    8'hF0:   r = 16'h011F;
                    8'hFD:   r = 16'h0131;
                    8'hFE:   r = 16'h015F;
                    default: r = {8'h00, b};
                endcase
            end
            MODE_6937: begin
                if (b inside {[8'hA8:8'hBA]}) begin
                    off = b - 8'hA8;
                    r   = rom_a8(off[4:0]);
                end else if (b inside {[8'hD0:8'hD7]}) begin
                    r = rom_d0(b[2:0]);
                end else if (b >= 8'hDC) begin
                    off = b - 8'hDC;
                    r   = rom_dc(off[5:0]);
                end
            end
            default: r = {8'h00, b};
        endcase
        return r;
    endfunction

    // Apply a held diacritic to the following byte
    function automatic cp_t combine(input logic [3:0] d_lo, input logic [7:0] b);
        cp_t base;
        cp_t r;
        logic hit;
        hit  = 1'b1;
        base = 16'h0000;
        case (b & 8'hDF)
            8'h41:   base = 16'h00C0;
            8'h45:   base = 16'h00C8;
            8'h49:   base = 16'h00CC;
            8'h4F:   base = 16'h00D2;
            8'h55:   base = 16'h00D9;
            default: hit = 1'b0;
        endcase
        if (hit && d_lo >= 4'd1 && d_lo <= 4'd3) begin
            r = base + {12'h000, d_lo - 4'd1} + {8'h00, b & 8'h20};
        end else begin
            r = {8'h00, b};
        end
        return r;
    endfunction

    // Number of UTF-8 bytes for a code point
    function automatic logic [1:0] utf8_len(input cp_t cp);
        logic [1:0] n;
        if (cp < 16'h0080) begin
            n = 2'd1;
        end else if (cp < 16'h0800) begin
            n = 2'd2;
        end else begin
            n = 2'd3;
        end
        return n;
    endfunction

    // One byte of the UTF-8 encoding of a code point
    function automatic logic [7:0] utf8_byte(input cp_t cp, input logic [1:0] idx);
        logic [7:0] r;
        r = cp[7:0];
        case (utf8_len(cp))
            2'd2: begin
                r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            end
            2'd3: begin
                case (idx)
                    2'd0:    r = {4'b1110, cp[15:12]};
                    2'd1:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
            default: r = cp[7:0];
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/dvbu_queue.sv
// Short code point queue between the decoder front and the UTF-8 serializer.
`default_nettype none

module dvbu_queue
    import dvbu_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cp_push_t    push,
    input  wire logic        pop,
    output cp_t              head,
    output queue_stat_t      stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cp_t              mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_FULL);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && !stat.full;
    assign do_pop     = pop && !stat.empty;

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed code points
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.cp;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dvbu_front.sv
// Input side: table selection, diacritic holding and code point lookup.
`default_nettype none

module dvbu_front
    import dvbu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] string_first
    input  wire logic        s_tlast,   // string_last
    input  wire queue_stat_t q_stat,
    output cp_push_t         push
);

    logic [1:0] mode_reg, mode_next;
    logic       held_valid_reg, held_valid_next;
    logic [3:0] held_lo_reg, held_lo_next;

    logic       accept;
    logic [1:0] new_mode;
    logic [1:0] mode_eff;
    logic       held_eff;
    logic       printable;
    logic       is_diac;
    logic       emit;
    logic       hold;
    cp_t        cp;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    // Decode the table selector of a string's first byte
    always_comb begin
        if (s_tdata == 8'h01) begin
            new_mode = MODE_8859_5;
        end else if (s_tdata == 8'h05) begin
            new_mode = MODE_8859_9;
        end else if (s_tdata >= 8'h20) begin
            new_mode = MODE_6937;
        end else begin
            new_mode = MODE_PASS;
        end
    end

    assign mode_eff  = s_tuser ? new_mode : mode_reg;
    assign held_eff  = held_valid_reg && !s_tuser;
    assign printable = (s_tdata[6:5] != 2'b00);
    assign is_diac   = (mode_eff == MODE_6937) && (s_tdata[7:4] == 4'hC);
    assign hold      = !held_eff && is_diac && !s_tlast;
    assign emit      = held_eff || (printable && !hold);

    // Pick the code point for this item
    always_comb begin
        if (held_eff) begin
            if (s_tdata != 8'h00) begin
                cp = combine(held_lo_reg, s_tdata);
            end else begin
                cp = {8'h00, 4'hC, held_lo_reg};
            end
        end else if (is_diac) begin
            cp = {8'h00, s_tdata};
        end else begin
            cp = map_byte(mode_eff, s_tdata);
        end
    end

    assign push.valid = accept && emit;
    assign push.cp    = cp;

    // Update table and held diacritic on each accepted item
    always_comb begin
        mode_next       = mode_reg;
        held_valid_next = held_valid_reg;
        held_lo_next    = held_lo_reg;
        if (accept) begin
            mode_next       = mode_eff;
            held_valid_next = hold;
            if (hold) begin
                held_lo_next = s_tdata[3:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_PASS;
            held_valid_reg <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_lo_reg <= held_lo_next;
    end

endmodule

`default_nettype wire

// File: rtl/dvbu_back.sv
// Output side: serialize queued code points into UTF-8 bytes.
`default_nettype none

module dvbu_back
    import dvbu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cp_t         head,
    input  wire queue_stat_t q_stat,
    output logic             pop,
    output back_stat_t       stat,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] utf8_byte
    output logic             m_tlast    // run_last
);

    logic       busy_reg, busy_next;
    cp_t        cp_reg, cp_next;
    logic [1:0] len_reg, len_next;
    logic [1:0] idx_reg, idx_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;
    logic       out_free;
    logic [1:0] head_len;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign head_len  = utf8_len(head);
    assign stat.busy = busy_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

    // Load the output register from the current code point or the queue head
    always_comb begin
        busy_next     = busy_reg;
        cp_next       = cp_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        pop           = 1'b0;
        if (out_free) begin
            if (busy_reg) begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = utf8_byte(cp_reg, idx_reg);
                m_tlast_next  = (idx_reg == len_reg - 2'd1);
                if (idx_reg == len_reg - 2'd1) begin
                    busy_next = 1'b0;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end else if (!q_stat.empty) begin
                pop           = 1'b1;
                m_tvalid_next = 1'b1;
                m_tdata_next  = utf8_byte(head, 2'd0);
                m_tlast_next  = (head_len == 2'd1);
                if (head_len != 2'd1) begin
                    busy_next = 1'b1;
                    cp_next   = head;
                    len_next  = head_len;
                    idx_next  = 2'd1;
                end
            end else begin
                m_tvalid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_reg      <= cp_next;
        len_reg     <= len_next;
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

`default_nettype wire

// File: rtl/dvb_text_to_utf8_decoder.sv
// DVB SI text to UTF-8 decoder. Each input item is one byte of a DVB text string; tuser marks
// the first byte of a string (it selects ISO 8859-5, ISO 8859-9, ISO 6937 or pass-through and
// is then decoded itself) and tlast marks its final byte. Each output item is one UTF-8 byte,
// with tlast on the last byte that an input byte produces. An input byte yields zero to three
// output bytes: control bytes are dropped and an ISO 6937 diacritic is held until the next
// byte. The front decodes a byte in the cycle it is accepted and pushes its code point into a
// QUEUE_DEPTH-entry queue (QUEUE_DEPTH of 2 or more); the UTF-8 serializer sends one byte per
// cycle while m_tready is high and so sets the sustained rate. Input is taken every cycle while
// the queue has room; the first output byte of an input byte passes through the queue and then
// the output register. There is no clearing pass after reset.
`default_nettype none

`include "dvb_text_to_utf8_decoder_macros.svh"

module dvb_text_to_utf8_decoder
    import dvbu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tuser,   // [0] string_first
    input  wire logic       s_tlast,   // string_last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] utf8_byte
    output logic            m_tlast    // run_last
);

    cp_push_t    push;
    queue_stat_t q_stat;
    back_stat_t  b_stat;
    cp_t         head;
    logic        pop;

    dvbu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (push)
    );

    dvbu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .stat    (q_stat)
    );

    dvbu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .stat     (b_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A multi-byte character in progress always has a byte on the output
    `DVBU_ASSERT_IMPLIES(a_busy_valid, aclk, aresetn, b_stat.busy, m_tvalid, "busy without output")

    // Queue never reports empty and full together
    `DVBU_ASSERT_ALWAYS(a_qstat, aclk, aresetn, !(q_stat.empty && q_stat.full), "empty and full")

    // A decoded character is never pushed into a full queue
    `DVBU_ASSERT_IMPLIES(a_no_push_full, aclk, aresetn, push.valid, !q_stat.full, "push when full")

endmodule

`default_nettype wire

// File: sim/dvb_text_to_utf8_decoder_tb.sv
// Self-checking testbench for the DVB text to UTF-8 decoder over its stream ports.
`timescale 1ns / 1ps

module dvb_text_to_utf8_decoder_tb;
    import dvbu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 30;
    localparam int DRAIN_CYCLES = 10;

    // ISO 6937 tables, entry 0 in the top bits
    localparam logic [19*16-1:0] ISO6937_A8 = {
        16'h00A4, 16'h2018, 16'h201C, 16'h00AB, 16'h2190, 16'h2191, 16'h2192, 16'h2193,
        16'h00B0, 16'h00B1, 16'h00B2, 16'h00B3, 16'h00D7, 16'h00B5, 16'h00B6, 16'h00B7,
        16'h00F7, 16'h2019, 16'h201D
    };
    localparam logic [8*16-1:0] ISO6937_D0 = {
        16'h2014, 16'h00B9, 16'h00AE, 16'h00A9, 16'h2122, 16'h266A, 16'h00AC, 16'h00A6
    };
    localparam logic [36*16-1:0] ISO6937_DC = {
        16'h215B, 16'h215C, 16'h215D, 16'h215E, 16'h2126, 16'h00C6, 16'h00D0, 16'h00AA,
        16'h0126, 16'h00E5, 16'h0132, 16'h013F, 16'h0141, 16'h00D8, 16'h0152, 16'h00BA,
        16'h00DE, 16'h0166, 16'h014A, 16'h0149, 16'h0138, 16'h00E6, 16'h0111, 16'h00F0,
        16'h0127, 16'h0131, 16'h0133, 16'h0140, 16'h0142, 16'h00F8, 16'h0153, 16'h00DF,
        16'h00FE, 16'h0167, 16'h014B, 16'h00AD
    };
    localparam logic [10*8-1:0] VOWELS = "AEIOUaeiou";

    typedef struct packed {
        logic [7:0] text_byte;
        logic       str_first;
        logic       str_last;
    } text_item_t;

    typedef struct packed {
        logic [7:0] code_unit;
        logic       run_end;
    } utf8_out_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tuser = 1'b0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    text_item_t pending_q[$];
    utf8_out_t  utf8_expect_q[$];

    // Decoder state as predicted
    logic [1:0] dec_mode = MODE_PASS;
    logic       held_ok = 1'b0;
    logic [7:0] held_mark = 8'h00;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_queued = 0;
    int items_taken = 0;
    int strings_queued = 0;
    int bytes_seen = 0;
    int accents_made = 0;
    int marks_flushed = 0;
    int errors = 0;
    int cycle_count = 0;

    dvb_text_to_utf8_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] data_byte
        .s_tuser  (s_tuser),   // [0] string_first
        .s_tlast  (s_tlast),   // string_last
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] utf8_byte
        .m_tlast  (m_tlast)    // run_last
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Pick the character table from the first byte of a string
    function automatic logic [1:0] select_table(input logic [7:0] b);
        logic [1:0] m;
        if (b == 8'h01) begin
            m = MODE_8859_5;
        end else if (b == 8'h05) begin
            m = MODE_8859_9;
        end else if (b >= 8'h20) begin
            m = MODE_6937;
        end else begin
            m = MODE_PASS;
        end
        return m;
    endfunction

    // Code point of one byte under the given table
    function automatic logic [15:0] table_lookup(input logic [1:0] m, input logic [7:0] b);
        logic [15:0] cp;
        int idx;
        cp = {8'h00, b};
        if (m == MODE_8859_5) begin
            if (b >= 8'hA1 && b != 8'hAD) begin
                if (b == 8'hF0) begin
                    cp = 16'h2116;
                end else if (b == 8'hFD) begin
                    cp = 16'h00A7;
                end else begin
                    cp = {8'h00, b} + 16'h0360;
                end
            end
        end else if (m == MODE_8859_9) begin
            case (b)
                8'hD0:   cp = 16'h011E;
                8'hDD:   cp = 16'h0130;
                8'hDE:   cp = 16'h015E;
                8'hF0:   cp = 16'h011F;
                8'hFD:   cp = 16'h0131;
                8'hFE:   cp = 16'h015F;
                default: cp = {8'h00, b};
            endcase
        end else if (m == MODE_6937) begin
            if (b >= 8'hA8 && b <= 8'hBA) begin
                idx = int'(b - 8'hA8);
                cp = ISO6937_A8[(18 - idx) * 16 +: 16];
            end else if (b >= 8'hD0 && b <= 8'hD7) begin
                idx = int'(b - 8'hD0);
                cp = ISO6937_D0[(7 - idx) * 16 +: 16];
            end else if (b >= 8'hDC) begin
                idx = int'(b - 8'hDC);
                cp = ISO6937_DC[(35 - idx) * 16 +: 16];
            end
        end
        return cp;
    endfunction

    // Accent a vowel with grave, acute or circumflex; anything else passes as is
    function automatic logic [15:0] apply_accent(input logic [7:0] mark, input logic [7:0] b);
        logic [15:0] base;
        logic        vowel;
        vowel = 1'b1;
        base = 16'h0000;
        case (b & 8'hDF)
            8'h41:   base = 16'h00C0;
            8'h45:   base = 16'h00C8;
            8'h49:   base = 16'h00CC;
            8'h4F:   base = 16'h00D2;
            8'h55:   base = 16'h00D9;
            default: vowel = 1'b0;
        endcase
        if (vowel && mark >= 8'hC1 && mark <= 8'hC3) begin
            return base + {8'h00, mark - 8'hC1} + {8'h00, b & 8'h20};
        end
        return {8'h00, b};
    endfunction

    // Queue the UTF-8 bytes of one code point
    task automatic push_utf8(input logic [15:0] cp);
        if (cp < 16'h0080) begin
            utf8_expect_q.push_back({cp[7:0], 1'b1});
        end else if (cp < 16'h0800) begin
            utf8_expect_q.push_back({3'b110, cp[10:6], 1'b0});
            utf8_expect_q.push_back({2'b10, cp[5:0], 1'b1});
        end else begin
            utf8_expect_q.push_back({4'b1110, cp[15:12], 1'b0});
            utf8_expect_q.push_back({2'b10, cp[11:6], 1'b0});
            utf8_expect_q.push_back({2'b10, cp[5:0], 1'b1});
        end
    endtask

    // Advance the predicted decoder by one accepted input byte
    task automatic predict_item(input logic [7:0] b, input logic f, input logic l);
        logic [15:0] cp;
        if (f) begin
            held_ok = 1'b0;
            held_mark = 8'h00;
            dec_mode = select_table(b);
        end
        if (held_ok) begin
            held_ok = 1'b0;
            if (b != 8'h00) begin
                cp = apply_accent(held_mark, b);
                if (cp != {8'h00, b}) accents_made++;
            end else begin
                cp = {8'h00, held_mark};
                marks_flushed++;
            end
            held_mark = 8'h00;
            push_utf8(cp);
        end else if ((b & 8'h60) != 8'h00) begin
            if (dec_mode == MODE_6937 && b >= 8'hC0 && b <= 8'hCF && !l) begin
                held_ok = 1'b1;
                held_mark = b;
            end else begin
                if (dec_mode == MODE_6937 && b >= 8'hC0 && b <= 8'hCF) marks_flushed++;
                push_utf8(table_lookup(dec_mode, b));
            end
        end
    endtask

    task automatic queue_item(input logic [7:0] b, input logic f, input logic l);
        pending_q.push_back({b, f, l});
        items_queued++;
    endtask

    // Build one well-formed string: a table byte, then text biased toward diacritic pairs
    task automatic queue_random_string(output int count);
        logic [7:0] body[$];
        int target;
        int pick;
        int k;
        pick = $urandom_range(9);
        case (pick)
            0:       body.push_back(8'h01);
            1:       body.push_back(8'h05);
            7:       body.push_back(8'($urandom_range(8'h1F)));
            8, 9:    body.push_back(8'($urandom_range(255)));
            default: body.push_back(8'($urandom_range(8'h20, 8'hFF)));
        endcase
        target = $urandom_range(8) + 1;
        while (body.size() < target) begin
            pick = $urandom_range(9);
            if (pick < 3) begin
                body.push_back(8'hC0 + 8'($urandom_range(15)));
                if (body.size() < target) begin
                    if ($urandom_range(1) == 1) begin
                        k = $urandom_range(9);
                        body.push_back(VOWELS[k*8 +: 8]);
                    end else begin
                        body.push_back(8'($urandom_range(255)));
                    end
                end
            end else if (pick < 7) begin
                body.push_back(8'($urandom_range(8'h20, 8'h7F)));
            end else begin
                body.push_back(8'($urandom_range(255)));
            end
        end
        for (k = 0; k < body.size(); k++) begin
            queue_item(body[k], k == 0, k == body.size() - 1);
        end
        strings_queued++;
        count = body.size();
    endtask

    // Drive the input channel; predict each item as it is accepted
    always @(posedge aclk) begin : drive_proc
        text_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_item(s_tdata, s_tuser, s_tlast);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_q.pop_front();
                    s_tdata <= nxt.text_byte;
                    s_tuser <= nxt.str_first;
                    s_tlast <= nxt.str_last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Stall the result channel and check each accepted byte against the oldest expectation
    always @(posedge aclk) begin : watch_proc
        utf8_out_t want;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            bytes_seen++;
            if (utf8_expect_q.size() == 0) begin
                $display("%0t: unexpected item: utf8_byte %02h run_last %0b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = utf8_expect_q.pop_front();
                if (m_tdata !== want.code_unit) begin
                    $display("%0t: utf8_byte mismatch: expected %02h, got %02h",
                             $time, want.code_unit, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.run_end) begin
                    $display("%0t: run_last mismatch: expected %0b, got %0b",
                             $time, want.run_end, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stim_proc
        int phase;
        int made;
        int n;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Before any string start the table is pass-through
        queue_item(8'h41, 1'b0, 1'b0);
        queue_item(8'h00, 1'b0, 1'b0);
        queue_item(8'hFF, 1'b0, 1'b0);
        // ISO 8859-5, including the two special code points and the soft hyphen
        queue_item(8'h01, 1'b1, 1'b0);
        queue_item(8'hA1, 1'b0, 1'b0);
        queue_item(8'hF0, 1'b0, 1'b0);
        queue_item(8'hFD, 1'b0, 1'b0);
        queue_item(8'hAD, 1'b0, 1'b0);
        queue_item(8'hFF, 1'b0, 1'b1);
        // ISO 8859-9
        queue_item(8'h05, 1'b1, 1'b0);
        queue_item(8'hD0, 1'b0, 1'b0);
        queue_item(8'hFE, 1'b0, 1'b1);
        // ISO 6937: grave, acute, circumflex, a non-combining pair, mark before zero,
        // mark before a control byte, the three table ranges and a mark at string end
        queue_item(8'h20, 1'b1, 1'b0);
        queue_item(8'hC1, 1'b0, 1'b0);
        queue_item(8'h61, 1'b0, 1'b0);
        queue_item(8'hC2, 1'b0, 1'b0);
        queue_item(8'h45, 1'b0, 1'b0);
        queue_item(8'hC3, 1'b0, 1'b0);
        queue_item(8'h55, 1'b0, 1'b0);
        queue_item(8'hC8, 1'b0, 1'b0);
        queue_item(8'h78, 1'b0, 1'b0);
        queue_item(8'hC1, 1'b0, 1'b0);
        queue_item(8'h00, 1'b0, 1'b0);
        queue_item(8'hC2, 1'b0, 1'b0);
        queue_item(8'h85, 1'b0, 1'b0);
        queue_item(8'hA9, 1'b0, 1'b0);
        queue_item(8'hD5, 1'b0, 1'b0);
        queue_item(8'hFF, 1'b0, 1'b0);
        queue_item(8'hC3, 1'b0, 1'b1);
        // A mark opening a string is dropped by the next string start
        queue_item(8'hC1, 1'b1, 1'b0);
        queue_item(8'h03, 1'b1, 1'b0);
        queue_item(8'hE9, 1'b0, 1'b1);

        // Random strings with some noise, one phase per idling pattern
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            made = 0;
            while (made < ITEMS_PER_PHASE) begin
                if ($urandom_range(9) == 0) begin
                    queue_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                               1'($urandom_range(1)));
                    made++;
                end else begin
                    queue_random_string(n);
                    made += n;
                end
            end
            while (pending_q.size() != 0) @(posedge aclk);
        end

        // Drain
        while (items_taken != items_queued || utf8_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (utf8_expect_q.size() != 0) begin
            $display("%0t: %0d expected items never arrived", $time, utf8_expect_q.size());
            errors++;
        end

        $display("Sent %0d input bytes (%0d random strings) over four idling patterns,",
                 items_taken, strings_queued);
        $display("checked %0d UTF-8 bytes; %0d accents composed, %0d marks flushed alone",
                 bytes_seen, accents_made, marks_flushed);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: dvb_text_to_utf8_decoder.f
+incdir+rtl
rtl/dvbu_pkg.sv
rtl/dvbu_queue.sv
rtl/dvbu_front.sv
rtl/dvbu_back.sv
rtl/dvb_text_to_utf8_decoder.sv
sim/dvb_text_to_utf8_decoder_tb.sv
